FILE: rtl/well512_pkg.sv
package well512_pkg;

	typedef logic [31:0] word_t;
	typedef logic [3:0]  pool_idx_t;

	// Seeding recurrence multiplier and the WELL512 mixing mask
	localparam word_t SEED_MULT   = 32'd1812433253;
	localparam word_t TEMPER_MASK = 32'hDA44_2D24;

	// Tap offsets relative to the rotating position
	localparam pool_idx_t OFS_C13 = 4'd13;
	localparam pool_idx_t OFS_C9  = 4'd9;
	localparam pool_idx_t OFS_A15 = 4'd15;

	localparam pool_idx_t POOL_LAST = 4'd15;

	// Register index decoded from paddr[2]
	localparam logic REG_SEED = 1'b0;

endpackage

FILE: rtl/well512_ram.sv
module well512_ram #(
	parameter int W = 32,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/well512_random_generator_core.sv
// A request passes through pool access over the single read port of the pool RAM,
// 32 iterations of a radix-2 restoring divider and one handoff to the output register;
// req_stall holds off the next request until that handoff.
// A request with max_value all ones skips the divider.
// Reset: seed clears to 0 and the pool is reseeded with req_stall high;
// every seed write reruns the same seeding and clears the position.
module well512_random_generator_core (
	input  logic                    clk,
	input  logic                    arst_n,
	// request channel
	input  logic                    req_valid,
	output logic                    req_stall,
	input  well512_pkg::word_t      max_value,
	// response channel
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output well512_pkg::word_t      value,
	// configuration port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	import well512_pkg::*;

	// Sequencer codes
	localparam logic [3:0] ST_SEED0  = 4'd0;   // write pool[0] = seed
	localparam logic [3:0] ST_FMUL   = 4'd1;   // seeding multiply
	localparam logic [3:0] ST_FADD   = 4'd2;   // seeding add and write
	localparam logic [3:0] ST_IDLE   = 4'd3;
	localparam logic [3:0] ST_RD_A   = 4'd4;   // read pool[pos]
	localparam logic [3:0] ST_RD_C13 = 4'd5;   // read pool[pos+13], take a
	localparam logic [3:0] ST_RD_C9  = 4'd6;   // read pool[pos+9], form b
	localparam logic [3:0] ST_RD_A15 = 4'd7;   // read pool[pos+15], form c
	localparam logic [3:0] ST_WR_X   = 4'd8;   // write pool[pos] = x
	localparam logic [3:0] ST_WR_N   = 4'd9;   // write new word at pos+15
	localparam logic [3:0] ST_DIV    = 4'd10;  // remainder iterations
	localparam logic [3:0] ST_DONE   = 4'd11;  // hand result to output register

	logic [3:0]  state_q;
	word_t       seed_q;
	pool_idx_t   pos_q;
	pool_idx_t   fill_idx_q;
	word_t       prev_q;       // last seeded word
	word_t       mul_q;        // registered seeding product
	word_t       a_q, b_q, c_q, d_q;
	word_t       word_q;       // freshly generated word
	word_t       dsr_q;        // max_value + 1
	logic        full_q;       // max_value was all ones
	word_t       rem_q;
	word_t       dvd_q;
	logic [4:0]  cnt_q;
	word_t       res_q;
	word_t       value_q;
	logic        out_valid_q;

	logic        cfg_wr;
	logic        seed_wr;
	logic        req_acc;
	logic        out_load;

	logic        ram_we;
	pool_idx_t   ram_waddr;
	word_t       ram_wdata;
	pool_idx_t   ram_raddr;
	word_t       ram_rdata;

	word_t       fill_word;
	word_t       x_word;
	word_t       new_word;
	logic [32:0] rem_ext;
	logic [32:0] rem_diff;
	word_t       rem_next;

	// APB: always ready, one register at index 0
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign seed_wr = cfg_wr && (paddr[2] == REG_SEED);
	assign prdata  = (paddr[2] == REG_SEED) ? seed_q : '0;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;

	// Move a finished result into the output register once it is free or draining
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !rsp_stall);

	assign rsp_valid = out_valid_q;
	assign value     = value_q;

	// Datapath terms
	assign fill_word = mul_q + word_t'(fill_idx_q);
	assign x_word    = b_q ^ c_q;
	assign new_word  = a_q ^ b_q ^ d_q ^ (a_q << 2) ^ (b_q << 18) ^ (c_q << 28);

	// One restoring step: shift in the next dividend bit, subtract if it fits
	assign rem_ext  = {rem_q, dvd_q[31]};
	assign rem_diff = rem_ext - {1'b0, dsr_q};
	assign rem_next = rem_diff[32] ? rem_ext[31:0] : rem_diff[31:0];

	// Pool RAM ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = x_word;
		unique case (state_q)
			ST_SEED0: begin
				ram_we    = 1'b1;
				ram_waddr = '0;
				ram_wdata = seed_q;
			end
			ST_FADD: begin
				ram_we    = 1'b1;
				ram_waddr = fill_idx_q;
				ram_wdata = fill_word;
			end
			ST_WR_X: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q;
				ram_wdata = x_word;
			end
			ST_WR_N: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q + OFS_A15;
				ram_wdata = new_word;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_RD_C13: ram_raddr = pos_q + OFS_C13;
			ST_RD_C9:  ram_raddr = pos_q + OFS_C9;
			ST_RD_A15: ram_raddr = pos_q + OFS_A15;
			default:   ram_raddr = pos_q;
		endcase
	end

	well512_ram #(
		.W(32),
		.D(16)
	) u_pool (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SEED0;
			seed_q     <= '0;
			pos_q      <= '0;
			fill_idx_q <= '0;
			cnt_q      <= '0;
		end else if (seed_wr) begin
			// restart seeding from the new seed word
			seed_q     <= pwdata;
			state_q    <= ST_SEED0;
			pos_q      <= '0;
			fill_idx_q <= '0;
			cnt_q      <= '0;
		end else begin
			unique case (state_q)
				ST_SEED0: begin
					fill_idx_q <= 4'd1;
					pos_q      <= '0;
					state_q    <= ST_FMUL;
				end
				ST_FMUL: begin
					state_q <= ST_FADD;
				end
				ST_FADD: begin
					fill_idx_q <= fill_idx_q + 4'd1;
					state_q    <= (fill_idx_q == POOL_LAST) ? ST_IDLE : ST_FMUL;
				end
				ST_IDLE: begin
					if (req_acc) begin
						state_q <= ST_RD_A;
					end
				end
				ST_RD_A:   state_q <= ST_RD_C13;
				ST_RD_C13: state_q <= ST_RD_C9;
				ST_RD_C9:  state_q <= ST_RD_A15;
				ST_RD_A15: state_q <= ST_WR_X;
				ST_WR_X:   state_q <= ST_WR_N;
				ST_WR_N: begin
					// advance position; the new word sits at the old pos+15
					pos_q   <= pos_q + OFS_A15;
					state_q <= full_q ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_SEED0;
				end
			endcase
		end
	end

	// Datapath registers, no reset needed
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SEED0: begin
				prev_q <= seed_q;
			end
			ST_FMUL: begin
				mul_q <= word_t'(SEED_MULT * (prev_q ^ (prev_q >> 30)));
			end
			ST_FADD: begin
				prev_q <= fill_word;
			end
			ST_IDLE: begin
				if (req_acc) begin
					dsr_q  <= max_value + 32'd1;
					full_q <= (max_value == '1);
				end
			end
			ST_RD_C13: begin
				a_q <= ram_rdata;
			end
			ST_RD_C9: begin
				b_q <= a_q ^ ram_rdata ^ (a_q << 16) ^ (ram_rdata << 15);
			end
			ST_RD_A15: begin
				c_q <= ram_rdata ^ (ram_rdata >> 11);
			end
			ST_WR_X: begin
				a_q <= ram_rdata;
				d_q <= x_word ^ ((x_word << 5) & TEMPER_MASK);
			end
			ST_WR_N: begin
				word_q <= new_word;
				res_q  <= new_word;
				rem_q  <= '0;
				dvd_q  <= new_word;
			end
			ST_DIV: begin
				rem_q <= rem_next;
				dvd_q <= dvd_q << 1;
				if (cnt_q == 5'd31) begin
					res_q <= rem_next;
				end
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	// Output register: hold while stalled, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			value_q <= res_q;
		end
	end

	// A seed write always restarts seeding
	a_seed_restart: assert property (@(posedge clk) disable iff (!arst_n)
		seed_wr |=> (state_q == ST_SEED0))
		else $error("seed write did not restart seeding");

	// A new result only comes out of the handoff state
	a_valid_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result valid raised outside handoff");

	// Position only moves on a generated word or a reseed
	a_pos_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && $past(state_q == ST_IDLE) |-> $stable(pos_q))
		else $error("position changed while idle");

	// Divider count is parked at zero outside the iterations
	a_cnt_parked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_DIV) |-> (cnt_q == 5'd0))
		else $error("divider count not cleared");

	// The raw word passes untouched for a full-range bound
	a_full_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && full_q |-> (res_q == word_q))
		else $error("full-range result differs from raw word");

endmodule

FILE: dv/well512_random_generator_core_checker.sv
module well512_random_generator_core_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  well512_pkg::word_t max_value,
	input  logic               rsp_valid,
	input  logic               rsp_stall,
	input  well512_pkg::word_t value,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	input  logic [31:0]        prdata,
	input  logic               pready,
	output int                 fail_count,
	output int                 pending_values
);

	import well512_pkg::*;

	word_t     pool [16];
	pool_idx_t position;
	word_t     seed_word;
	word_t     expected_values [$];

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	// LCG fill of the pool; position restarts at zero
	function automatic void reseed_pool(input word_t s);
		pool[0] = s;
		for (int i = 1; i < 16; i++) begin
			pool[i] = SEED_MULT * (pool[i-1] ^ (pool[i-1] >> 30)) + 32'(i);
		end
		position = '0;
	endfunction

	// One step of the WELL512 recurrence
	function automatic word_t next_pool_word();
		word_t     a, b, c, d, x;
		pool_idx_t p, i13, i9;
		p   = position;
		i13 = p + OFS_C13;
		i9  = p + OFS_C9;
		a = pool[p];
		c = pool[i13];
		b = a ^ c ^ (a << 16) ^ (c << 15);
		c = pool[i9];
		c = c ^ (c >> 11);
		x = b ^ c;
		pool[p] = x;
		d = x ^ ((x << 5) & TEMPER_MASK);
		p = p + OFS_A15;
		a = pool[p];
		pool[p] = a ^ b ^ d ^ (a << 2) ^ (b << 18) ^ (c << 28);
		position = p;
		return pool[p];
	endfunction

	// all-ones bound passes the raw word through
	function automatic word_t bounded_word(input word_t bound);
		word_t w;
		w = next_pool_word();
		if (bound == '1) return w;
		return w % (bound + 32'd1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_t want;
		if (!arst_n) begin
			seed_word = '0;
			reseed_pool(seed_word);
			expected_values.delete();
			pending_values = 0;
			fail_count = 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[2] == REG_SEED) begin
						seed_word = pwdata;
						reseed_pool(seed_word);
					end
				end else if (paddr[2] == REG_SEED && prdata !== seed_word) begin
					report_mismatch($sformatf("seed readback %h, expected %h", prdata, seed_word));
				end
			end
			// retire the response before queuing a request taken at the same edge
			if (rsp_valid && !rsp_stall) begin
				if (expected_values.size() == 0) begin
					report_mismatch($sformatf("value %h with no request outstanding", value));
				end else begin
					want = expected_values.pop_front();
					if (value !== want)
						report_mismatch($sformatf("value %h, expected %h", value, want));
				end
			end
			if (req_valid && !req_stall)
				expected_values.push_back(bounded_word(max_value));
			pending_values = expected_values.size();
		end
	end

endmodule

FILE: dv/well512_random_generator_core_tb.sv
module well512_random_generator_core_tb;
	import well512_pkg::*;

	// Seed register decodes from paddr[2]; the other index is a dead slot
	localparam logic [2:0] SEED_ADDR   = {REG_SEED, 2'b00};
	localparam logic [2:0] UNUSED_ADDR = {~REG_SEED, 2'b00};
	// Pad a little past the latency of one transaction when settling
	localparam int SETTLE_CYCLES = 48;
	// Slowest run: ~650 transactions plus idle gaps on both
	// sides, plus a reseed per phase; take that several times over
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 100;
	localparam int PHASES      = 6;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	word_t       max_value;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	word_t       value;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int fail_count;
	int pending_values;

	// Idle odds: 0 disables the bursts, N starts one with a chance of 1 in N at each try
	int gap_odds   = 0;
	int stall_odds = 0;
	int stall_left = 0;
	int cycle_count = 0;

	well512_random_generator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.max_value (max_value),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.value     (value),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	well512_random_generator_core_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.max_value      (max_value),
		.rsp_valid      (rsp_valid),
		.rsp_stall      (rsp_stall),
		.value          (value),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.fail_count     (fail_count),
		.pending_values (pending_values)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop if the block hangs anywhere
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Response-side backpressure: hold stall for bursts of random length
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_stall  <= 1'b1;
		end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			stall_left <= $urandom_range(0, 3);
			rsp_stall  <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Offer one request transaction, maybe after an idle burst, and hold it
	// until the block takes it. Signals read right after the edge are the
	// values the block saw at that edge.
	task automatic request_word(input word_t bound);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_valid <= 1'b1;
		max_value <= bound;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// Drop valid, let every outstanding response come back, then pad.
	// Step one edge first so the checker has counted the last transaction.
	task automatic drain_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_values != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Setup cycle, then access cycle; the transfer lands when pready is high
	task automatic apb_access(input logic wr, input logic [2:0] addr, input word_t data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Mix of bound shapes: zero, full range, tiny, shifted-down random, wide random
	function automatic word_t random_bound();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return $urandom_range(1, 16);
			4, 5: return $urandom >> $urandom_range(1, 31);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		word_t phase_seed;

		// Drive every input to a known value from time zero
		arst_n    = 1'b0;
		req_valid <= 1'b0;
		max_value <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset seed of zero: walk the bound extremes while the pool is fresh.
		// Zero bound must give zero; all ones must give the raw word.
		request_word('0);
		request_word('1);
		request_word(32'd1);
		request_word(32'd2);
		request_word(32'd3);
		request_word(32'hFFFF_FFFE);
		request_word(32'h8000_0000);
		request_word(32'h7FFF_FFFF);
		request_word(32'hAAAA_AAAA);
		request_word(32'h5555_5555);
		request_word(32'h0000_FFFF);
		request_word(32'h0001_0000);
		request_word(32'd999);
		request_word('1);
		drain_results();

		// A write to the unused index must neither reseed nor change the seed
		apb_access(1'b0, SEED_ADDR, '0);
		apb_access(1'b1, UNUSED_ADDR, 32'hFFFF_FFFF);
		apb_access(1'b0, SEED_ADDR, '0);
		request_word('1);
		request_word(32'd6);
		request_word('0);
		drain_results();

		// Top seed value, with idling switched on
		gap_odds   = 3;
		stall_odds = 4;
		apb_access(1'b1, SEED_ADDR, 32'hFFFF_FFFF);
		apb_access(1'b0, SEED_ADDR, '0);
		request_word('0);
		request_word('1);
		request_word(32'hFFFF_FFFE);
		request_word(32'd1);
		request_word(32'd12345);
		drain_results();

		// Random phases, each under a new seed; the last one runs flat out
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: phase_seed = '0;
				1: phase_seed = 32'd1;
				2: phase_seed = 32'h8000_0000;
				default: phase_seed = $urandom;
			endcase
			if (phase == PHASES - 1) begin
				gap_odds   = 0;
				stall_odds = 0;
			end else begin
				gap_odds   = $urandom_range(0, 1) ? $urandom_range(2, 6) : 0;
				stall_odds = $urandom_range(0, 1) ? $urandom_range(2, 6) : 0;
			end
			apb_access(1'b1, SEED_ADDR, phase_seed);
			apb_access(1'b0, SEED_ADDR, '0);
			repeat (PHASE_ITEMS) request_word(random_bound());
			drain_results();
		end

		if (fail_count == 0 && pending_values == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
